// ===== hdl/rau_pkg.sv =====
// Package for the rational arithmetic unit: beat structs, modes, status codes.
// No dependencies.
`timescale 1ns / 1ps
package rau_pkg;
	localparam int DEF_WIDTH = 32;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2,
		MODE_NRM = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_ZOZ  = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] a_num;
		logic [31:0] a_den;
		logic [31:0] b_num;
		logic [31:0] b_den;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] result_num;
		logic [30:0] result_den;
		logic [1:0]  status;
	} out_beat_t;
endpackage

// ===== hdl/rational_arith_unit.sv =====
// Rational arithmetic unit: add/sub/mul/normalise two fractions, reduce by gcd.
// Depends on rau_pkg. One multiplier serves all products, one divider gcd and divisions.
//
//  channel  dir  valid     stall     payload
//  in       in   in_valid  in_stall  in_data  (rau_pkg::in_beat_t)
//  out      out  out_valid out_stall out_data (rau_pkg::out_beat_t)
//
// One beat first forms its products by shift-add, one bit a cycle (three products
// for add/sub, two for multiply, none for normalise), then runs one division per Euclid
// remainder step (restoring divider, one quotient bit a cycle) until the remainder is
// zero, then two more such divisions. Accept, range check and result load each have a state.
// Out-of-range and 0/0 beats skip the gcd and divisions.
// in_stall is high from acceptance until the result beat is taken; the result
// waits in out_data while out_stall is high. Reset clears the sequencer only.
`timescale 1ns / 1ps
module rational_arith_unit #(
	parameter int WIDTH = rau_pkg::DEF_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rau_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output rau_pkg::out_beat_t  out_data
);
	localparam int PW = 2 * WIDTH + 2;  // product / sum width
	localparam int CW = $clog2(PW + 1);

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_MUL  = 8'b00000010,
		S_CHK  = 8'b00000100,
		S_GCD  = 8'b00001000,
		S_DIVN = 8'b00010000,
		S_DIVD = 8'b00100000,
		S_FIN  = 8'b01000000,
		S_OUT  = 8'b10000000
	} state_t;

	state_t state_q;
	logic [1:0] mode_q;
	logic signed [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic [1:0] pidx_q;               // which product
	logic signed [PW-1:0] p0_q, p1_q, p2_q; // an*bd (or an*bn), bn*ad, ad*bd
	// shared shift-add multiplier registers
	logic [WIDTH:0] mcand_q, mplier_q;
	logic [PW-1:0] macc_q;
	logic mneg_q;
	logic [CW-1:0] cnt_q;
	// shared divider
	logic [PW-1:0] dvd_q, rem_q, dvs_q;
	logic neg_q;
	logic [PW-1:0] un_q, ud_q, gx_q, gy_q;
	logic gdiv_q;                     // divider busy
	logic [PW-1:0] qn_q;
	logic [1:0] st_q;

	function automatic logic signed [WIDTH-1:0] sx(input logic [31:0] v);
		sx = v[WIDTH-1:0];
	endfunction

	// operand selection for product
	logic signed [WIDTH:0] opa, opb;
	always_comb begin
		case (pidx_q)
			2'd0: begin
				opa = {an_q[WIDTH-1], an_q};
				opb = (mode_q == rau_pkg::MODE_MUL) ? {bn_q[WIDTH-1], bn_q}
				                                    : {bd_q[WIDTH-1], bd_q};
			end
			2'd1: begin
				opa = (mode_q == rau_pkg::MODE_SUB) ? -{bn_q[WIDTH-1], bn_q}
				                                    : {bn_q[WIDTH-1], bn_q};
				opb = {ad_q[WIDTH-1], ad_q};
			end
			default: begin
				opa = {ad_q[WIDTH-1], ad_q};
				opb = {bd_q[WIDTH-1], bd_q};
			end
		endcase
	end

	// divider step: one restoring bit
	logic [PW-1:0] rsh, rdiff;
	logic rge;
	assign rsh   = {rem_q[PW-2:0], dvd_q[PW-1]};
	assign rge   = rsh >= dvs_q;
	assign rdiff = rsh - dvs_q;

	// range check on unreduced parts
	localparam logic signed [PW-1:0] LO = -(PW'(1) <<< (WIDTH - 1));
	localparam logic signed [PW-1:0] HI = (PW'(1) <<< (WIDTH - 1)) - PW'(1);
	logic signed [PW-1:0] nsel, dsel;
	assign nsel = (mode_q == rau_pkg::MODE_NRM) ? PW'(an_q) :
	              (mode_q == rau_pkg::MODE_MUL) ? p0_q : p0_q + p1_q;
	assign dsel = (mode_q == rau_pkg::MODE_NRM) ? PW'(ad_q) : p2_q;

	logic [PW-1:0] hiu, lou;
	assign hiu = PW'(HI);
	assign lou = hiu + PW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gdiv_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q <= in_data.mode;
						an_q <= sx(in_data.a_num);
						ad_q <= sx(in_data.a_den);
						bn_q <= sx(in_data.b_num);
						bd_q <= sx(in_data.b_den);
						pidx_q <= 2'd0;
						cnt_q <= '0;
						macc_q <= '0;
						state_q <= (in_data.mode == rau_pkg::MODE_NRM) ? S_CHK : S_MUL;
					end
				end
				S_MUL: begin
					if (cnt_q == '0) begin
						// load operands as magnitudes
						mcand_q <= opa[WIDTH] ? -opa : opa;
						mplier_q <= opb[WIDTH] ? -opb : opb;
						mneg_q <= opa[WIDTH] ^ opb[WIDTH];
						cnt_q <= CW'(1);
					end else if (cnt_q <= CW'(WIDTH + 1)) begin
						if (mplier_q[0])
							macc_q <= macc_q + (PW'(mcand_q) << (cnt_q - CW'(1)));
						mplier_q <= mplier_q >> 1;
						cnt_q <= cnt_q + CW'(1);
					end else begin
						case (pidx_q)
							2'd0: p0_q <= mneg_q ? -macc_q : macc_q;
							2'd1: p1_q <= mneg_q ? -macc_q : macc_q;
							default: p2_q <= mneg_q ? -macc_q : macc_q;
						endcase
						macc_q <= '0;
						mneg_q <= 1'b0;
						mplier_q <= '0;
						cnt_q <= '0;
						if (pidx_q == 2'd2 || (mode_q == rau_pkg::MODE_MUL && pidx_q == 2'd0))
							pidx_q <= pidx_q + 2'd1 + ((pidx_q == 2'd0) ? 2'd1 : 2'd0);
						else
							pidx_q <= pidx_q + 2'd1;
						if (pidx_q == 2'd2)
							state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (nsel < LO || nsel > HI || dsel < LO || dsel > HI) begin
						st_q <= rau_pkg::ST_OVF;
						state_q <= S_FIN;
					end else if (nsel == '0 && dsel == '0) begin
						st_q <= rau_pkg::ST_ZOZ;
						state_q <= S_FIN;
					end else begin
						logic signed [PW-1:0] n2, d2;
						n2 = dsel[PW-1] ? -nsel : nsel;
						d2 = dsel[PW-1] ? -dsel : dsel;
						neg_q <= n2[PW-1];
						un_q <= n2[PW-1] ? -n2 : n2;
						ud_q <= d2;
						gx_q <= n2[PW-1] ? -n2 : n2;
						gy_q <= d2;
						st_q <= rau_pkg::ST_OK;
						gdiv_q <= 1'b0;
						state_q <= S_GCD;
					end
				end
				S_GCD, S_DIVN, S_DIVD: begin
					if (!gdiv_q) begin
						if (state_q == S_GCD && gy_q == '0) begin
							state_q <= S_DIVN;
						end else begin
							dvd_q <= (state_q == S_GCD) ? gx_q :
							         (state_q == S_DIVN) ? un_q : ud_q;
							dvs_q <= (state_q == S_GCD) ? gy_q : gx_q;
							rem_q <= '0;
							cnt_q <= '0;
							gdiv_q <= 1'b1;
						end
					end else if (cnt_q != CW'(PW)) begin
						rem_q <= rge ? rdiff : rsh;
						dvd_q <= {dvd_q[PW-2:0], rge};
						cnt_q <= cnt_q + CW'(1);
					end else begin
						gdiv_q <= 1'b0;
						case (state_q)
							S_GCD: begin
								gx_q <= gy_q;
								gy_q <= rem_q;
							end
							S_DIVN: begin
								qn_q <= dvd_q;
								state_q <= S_DIVD;
							end
							default: begin
								if ((!neg_q && qn_q > hiu) || (neg_q && qn_q > lou) ||
								    dvd_q > hiu) begin
									st_q <= rau_pkg::ST_OVF;
								end else begin
									un_q <= neg_q ? -qn_q : qn_q;
									ud_q <= dvd_q;
								end
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_FIN: begin
					out_data.status <= st_q;
					out_data.result_num <= (st_q == rau_pkg::ST_OK) ?
						32'(signed'(un_q[WIDTH-1:0])) : '0;
					out_data.result_den <= (st_q == rau_pkg::ST_OK) ? 31'(ud_q[WIDTH-1:0]) : '0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
endmodule
